### src/m3i_pkg.sv
// m3i_pkg: shared widths, index tables and pipeline types for the 3x3 inverse.
// No dependencies; used by m3i_div_stage and matrix3x3_inverse.
package m3i_pkg;

  localparam int ELEM_W = 32;  // matrix element width
  localparam int N_ELEM = 9;   // elements per matrix
  localparam int PROD_W = 64;  // element x element product
  localparam int COF_W  = 65;  // signed cofactor (difference of two products)
  localparam int MAG_W  = 64;  // cofactor magnitude
  localparam int LO_W   = 33;  // low slice of a cofactor in the det split
  localparam int PPL_W  = 66;  // element x (unsigned low slice)
  localparam int PPH_W  = 64;  // element x (signed high slice)
  localparam int DET_W  = 97;  // signed determinant
  localparam int DMAG_W = 96;  // determinant magnitude
  localparam int QUO_W  = 33;  // quotient bits kept by the divider

  // cyclic row/column neighbors for the cofactor rule
  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  typedef struct packed {
    logic en;     // pipeline advance
    logic valid;  // data presented to the stage is live
  } ctl_t;

  // per-transaction data that rides alongside the divider
  typedef struct packed {
    logic [N_ELEM-1:0][ELEM_W-1:0] m;     // original input elements
    logic [N_ELEM-1:0]             nneg;  // cofactor sign
    logic                          dneg;  // determinant sign
    logic                          dzero; // determinant is zero
    logic [N_ELEM-1:0]             ovf;   // quotient >= 2^QUO_W
  } side_t;

endpackage

### src/m3i_div_stage.sv
// m3i_div_stage: one registered restoring-division step for all nine lanes.
// Depends on m3i_pkg.
module m3i_div_stage #(
  parameter int REM_W   = 130,
  parameter int BIT_IDX = 0
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  m3i_pkg::ctl_t                                    ctl_i,
  output logic                                             valid_o,
  input  logic [m3i_pkg::N_ELEM-1:0][REM_W-1:0]            rem_i,
  input  logic [m3i_pkg::N_ELEM-1:0][m3i_pkg::QUO_W-1:0]   quo_i,
  input  logic [m3i_pkg::DMAG_W-1:0]                       dmag_i,
  output logic [m3i_pkg::N_ELEM-1:0][REM_W-1:0]            rem_o,
  output logic [m3i_pkg::N_ELEM-1:0][m3i_pkg::QUO_W-1:0]   quo_o,
  output logic [m3i_pkg::DMAG_W-1:0]                       dmag_o
);

  logic [REM_W-1:0]                                    dsh;
  logic [m3i_pkg::N_ELEM-1:0][REM_W-1:0]               rem_d, rem_q;
  logic [m3i_pkg::N_ELEM-1:0][m3i_pkg::QUO_W-1:0]      quo_d, quo_q;
  logic [m3i_pkg::DMAG_W-1:0]                          dmag_q;
  logic                                                valid_q;

  assign dsh = REM_W'(dmag_i) << BIT_IDX;

  always_comb begin
    for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
      rem_d[k] = rem_i[k];
      quo_d[k] = quo_i[k];
      if (rem_i[k] >= dsh) begin
        rem_d[k]          = rem_i[k] - dsh;
        quo_d[k][BIT_IDX] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dmag_q <= dmag_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign dmag_o  = dmag_q;

endmodule

### src/matrix3x3_inverse.sv
// matrix3x3_inverse: pipelined 3x3 fixed-point inverse via adjugate / determinant.
// Depends on m3i_pkg and m3i_div_stage.
// Pipeline: 6 arithmetic stages, 33 divider steps, then an output register.
// Throughput: one transaction per cycle unless the output stalls; the 33-step divider is fully pipelined.
// A stall while a result is held at the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_ni low, async) clears all valid bits; data registers are not reset.
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] in_r0c0_i,
  input  logic [31:0] in_r0c1_i,
  input  logic [31:0] in_r0c2_i,
  input  logic [31:0] in_r1c0_i,
  input  logic [31:0] in_r1c1_i,
  input  logic [31:0] in_r1c2_i,
  input  logic [31:0] in_r2c0_i,
  input  logic [31:0] in_r2c1_i,
  input  logic [31:0] in_r2c2_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_r0c0_o,
  output logic [31:0] out_r0c1_o,
  output logic [31:0] out_r0c2_o,
  output logic [31:0] out_r1c0_o,
  output logic [31:0] out_r1c1_o,
  output logic [31:0] out_r1c2_o,
  output logic [31:0] out_r2c0_o,
  output logic [31:0] out_r2c1_o,
  output logic [31:0] out_r2c2_o,
  output logic        singular_o,
  output logic        saturated_o
);

  localparam int NE    = m3i_pkg::N_ELEM;
  localparam int EW    = m3i_pkg::ELEM_W;
  localparam int QW    = m3i_pkg::QUO_W;
  // numerator = |cofactor| scaled by 2^(2F)
  localparam int NUM_W = m3i_pkg::MAG_W + 2 * FRAC_BITS;
  localparam int REM_W = ((NUM_W > m3i_pkg::DMAG_W + QW) ? NUM_W
                                                         : m3i_pkg::DMAG_W + QW) + 1;
  localparam logic [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};

  // Global advance: everything moves unless a finished result is held.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic [NE-1:0][EW-1:0] m_in;
  assign m_in = {in_r2c2_i, in_r2c1_i, in_r2c0_i,
                 in_r1c2_i, in_r1c1_i, in_r1c0_i,
                 in_r0c2_i, in_r0c1_i, in_r0c0_i};

  // ---------------- stage 1: 18 element products ----------------
  logic signed [m3i_pkg::PROD_W-1:0] pa_d [NE];
  logic signed [m3i_pkg::PROD_W-1:0] pb_d [NE];
  logic signed [m3i_pkg::PROD_W-1:0] pa_q [NE];
  logic signed [m3i_pkg::PROD_W-1:0] pb_q [NE];
  logic [NE-1:0][EW-1:0] m1_q;
  logic v1_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa_d[r*3+c] = $signed(m_in[m3i_pkg::NEXT1[r]*3 + m3i_pkg::NEXT1[c]])
                    * $signed(m_in[m3i_pkg::NEXT2[r]*3 + m3i_pkg::NEXT2[c]]);
        pb_d[r*3+c] = $signed(m_in[m3i_pkg::NEXT1[r]*3 + m3i_pkg::NEXT2[c]])
                    * $signed(m_in[m3i_pkg::NEXT2[r]*3 + m3i_pkg::NEXT1[c]]);
      end
    end
  end

  // ---------------- stage 2: cofactors ----------------
  logic signed [m3i_pkg::COF_W-1:0] cof_d [NE];
  logic signed [m3i_pkg::COF_W-1:0] cof_q [NE];
  logic [NE-1:0][EW-1:0] m2_q;
  logic v2_q;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      cof_d[k] = m3i_pkg::COF_W'(pa_q[k]) - m3i_pkg::COF_W'(pb_q[k]);
    end
  end

  // ---------------- stage 3: det partials, cofactor magnitudes ----------------
  // cofactor split into signed high and unsigned low slices keeps multipliers ~32x34
  logic signed [m3i_pkg::PPL_W-1:0] ppl_d [3];
  logic signed [m3i_pkg::PPH_W-1:0] pph_d [3];
  logic signed [m3i_pkg::PPL_W-1:0] ppl_q [3];
  logic signed [m3i_pkg::PPH_W-1:0] pph_q [3];
  logic signed [m3i_pkg::COF_W-1:0] cneg [NE];
  logic [NE-1:0][m3i_pkg::MAG_W-1:0] nmag_d, nmag3_q, nmag4_q, nmag5_q;
  logic [NE-1:0] nneg_d, nneg3_q, nneg4_q, nneg5_q;
  logic [NE-1:0][EW-1:0] m3_q, m4_q, m5_q;
  logic v3_q, v4_q, v5_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ppl_d[c] = $signed(m2_q[c])
               * $signed({1'b0, cof_q[c][m3i_pkg::LO_W-1:0]});
      pph_d[c] = $signed(m2_q[c])
               * $signed(cof_q[c][m3i_pkg::COF_W-1:m3i_pkg::LO_W]);
    end
    for (int k = 0; k < NE; k++) begin
      cneg[k]   = -cof_q[k];
      nneg_d[k] = cof_q[k][m3i_pkg::COF_W-1];
      nmag_d[k] = nneg_d[k] ? cneg[k][m3i_pkg::MAG_W-1:0]
                            : cof_q[k][m3i_pkg::MAG_W-1:0];
    end
  end

  // ---------------- stage 4: determinant (row-0 expansion) ----------------
  logic signed [m3i_pkg::DET_W-1:0] det_d, det_q;

  always_comb begin
    det_d = '0;
    for (int c = 0; c < 3; c++) begin
      det_d = det_d + m3i_pkg::DET_W'(ppl_q[c])
                    + (m3i_pkg::DET_W'(pph_q[c]) <<< m3i_pkg::LO_W);
    end
  end

  // ---------------- stage 5: determinant sign and magnitude ----------------
  logic signed [m3i_pkg::DET_W-1:0] dabs;
  logic [m3i_pkg::DMAG_W-1:0] dmag_d, dmag5_q;
  logic dneg_d, dzero_d, dneg5_q, dzero5_q;

  always_comb begin
    dabs    = -det_q;
    dneg_d  = det_q[m3i_pkg::DET_W-1];
    dzero_d = (det_q == '0);
    dmag_d  = dneg_d ? dabs[m3i_pkg::DMAG_W-1:0] : det_q[m3i_pkg::DMAG_W-1:0];
  end

  // ---------------- stage 6: divider entry, overflow detect ----------------
  logic [NE-1:0][REM_W-1:0] num_d;
  logic [NE-1:0]            ovf_d;
  logic [REM_W-1:0]         dtop;
  m3i_pkg::side_t           side0_d;

  always_comb begin
    dtop = REM_W'(dmag5_q) << QW;
    for (int k = 0; k < NE; k++) begin
      num_d[k] = REM_W'(nmag5_q[k]) << (2 * FRAC_BITS);
      ovf_d[k] = (num_d[k] >= dtop);
    end
    side0_d.m     = m5_q;
    side0_d.nneg  = nneg5_q;
    side0_d.dneg  = dneg5_q;
    side0_d.dzero = dzero5_q;
    side0_d.ovf   = ovf_d;
  end

  // divider chain: index 0 is the entry register, index QW the last step
  logic [NE-1:0][REM_W-1:0] rem_s  [QW+1];
  logic [NE-1:0][QW-1:0]    quo_s  [QW+1];
  logic [m3i_pkg::DMAG_W-1:0] dmag_s [QW+1];
  m3i_pkg::side_t           side_s [QW+1];
  logic [QW:0]              v_s;

  // divider entry register
  logic                       v0_q;
  logic [NE-1:0][REM_W-1:0]   rem0_q;
  logic [m3i_pkg::DMAG_W-1:0] dmag0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v0_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v0_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= m_in;
      for (int k = 0; k < NE; k++) begin
        pa_q[k]  <= pa_d[k];
        pb_q[k]  <= pb_d[k];
        cof_q[k] <= cof_d[k];
      end
      m2_q <= m1_q;
      for (int c = 0; c < 3; c++) begin
        ppl_q[c] <= ppl_d[c];
        pph_q[c] <= pph_d[c];
      end
      nmag3_q <= nmag_d;
      nneg3_q <= nneg_d;
      m3_q    <= m2_q;
      det_q   <= det_d;
      nmag4_q <= nmag3_q;
      nneg4_q <= nneg3_q;
      m4_q    <= m3_q;
      dmag5_q  <= dmag_d;
      dneg5_q  <= dneg_d;
      dzero5_q <= dzero_d;
      nmag5_q  <= nmag4_q;
      nneg5_q  <= nneg4_q;
      m5_q     <= m4_q;
      rem0_q    <= num_d;
      dmag0_q   <= dmag5_q;
      side_s[0] <= side0_d;
    end
  end

  assign v_s[0]    = v0_q;
  assign rem_s[0]  = rem0_q;
  assign quo_s[0]  = '0;
  assign dmag_s[0] = dmag0_q;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < QW; i++) begin : g_div
    m3i_pkg::ctl_t ctl;
    assign ctl.en    = en;
    assign ctl.valid = v_s[i];

    m3i_div_stage #(
      .REM_W   (REM_W),
      .BIT_IDX (QW - 1 - i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .valid_o (v_s[i+1]),
      .rem_i   (rem_s[i]),
      .quo_i   (quo_s[i]),
      .dmag_i  (dmag_s[i]),
      .rem_o   (rem_s[i+1]),
      .quo_o   (quo_s[i+1]),
      .dmag_o  (dmag_s[i+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_s[i+1] <= side_s[i];
      end
    end
  end

  // ---------------- output stage: sign, saturation, singular bypass ----------------
  m3i_pkg::side_t        sd;
  logic [NE-1:0][QW-1:0] qv;
  logic [NE-1:0][EW-1:0] res;
  logic [NE-1:0]         lane_sat;
  logic [NE-1:0][EW-1:0] out_d, out_q;
  logic                  sing_d, sat_d, sing_q, sat_q;
  logic                  sgn, qneg;

  assign sd = side_s[QW];
  assign qv = quo_s[QW];

  always_comb begin
    sgn  = 1'b0;
    qneg = 1'b0;
    for (int k = 0; k < NE; k++) begin
      sgn         = sd.nneg[k] ^ sd.dneg;
      qneg        = sgn && (qv[k] != '0);
      lane_sat[k] = 1'b0;
      res[k]      = qv[k][EW-1:0];
      if (sd.ovf[k] || qv[k][QW-1]) begin
        // quotient at least 2^32: clip, sign known from operands
        res[k]      = sgn ? SAT_MIN : SAT_MAX;
        lane_sat[k] = 1'b1;
      end else if (qneg) begin
        if (qv[k][EW-1:0] > SAT_MIN) begin
          res[k]      = SAT_MIN;
          lane_sat[k] = 1'b1;
        end else begin
          res[k] = EW'(0) - qv[k][EW-1:0];
        end
      end else if (qv[k][EW-1]) begin
        res[k]      = SAT_MAX;
        lane_sat[k] = 1'b1;
      end
    end
    // adjugate: output (r,c) comes from cofactor (c,r)
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        out_d[r*3+c] = sd.dzero ? sd.m[r*3+c] : res[c*3+r];
      end
    end
    sing_d = sd.dzero;
    sat_d  = !sd.dzero && (|lane_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_s[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      sing_q <= sing_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_r0c0_o  = out_q[0];
  assign out_r0c1_o  = out_q[1];
  assign out_r0c2_o  = out_q[2];
  assign out_r1c0_o  = out_q[3];
  assign out_r1c1_o  = out_q[4];
  assign out_r1c2_o  = out_q[5];
  assign out_r2c0_o  = out_q[6];
  assign out_r2c1_o  = out_q[7];
  assign out_r2c2_o  = out_q[8];
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

  // ---------------- assertions ----------------
  logic hit_limit;
  always_comb begin
    hit_limit = 1'b0;
    for (int k = 0; k < NE; k++) begin
      hit_limit = hit_limit || (out_q[k] == SAT_MAX) || (out_q[k] == SAT_MIN);
    end
  end

  // a singular result never reports clipping
  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(sing_q && sat_q))
    else $error("singular and saturated both set");

  // a clipped result carries at least one range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |-> hit_limit)
    else $error("saturated flag without a clipped element");

  // a frozen pipeline keeps the divider entry valid bit
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_s[0]))
    else $error("pipeline moved while stalled");

endmodule

### tb/matrix3x3_inverse_test.sv
// matrix3x3_inverse_test: self-checking bench for the pipelined 3x3 fixed-point inverse.
// Depends on matrix3x3_inverse (and its m3i_pkg and m3i_div_stage) only.
`timescale 1ns / 100ps

module matrix3x3_inverse_test;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 1850;
  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [31:0] elem_t;
  typedef elem_t mat_t [9];

  typedef struct {
    elem_t e [9];
    logic  singular;
    logic  saturated;
  } inverse_t;

  // Exact-arithmetic inverse: adjugate over determinant, truncated toward zero,
  // clipped to 32 bits. Singular matrices pass through unchanged.
  function automatic inverse_t compute_inverse(input mat_t m);
    logic signed [127:0] a [3][3];
    logic signed [127:0] cof [3][3];
    logic signed [127:0] det, num, quo;
    inverse_t res;
    res.singular = 1'b0;
    res.saturated = 1'b0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        a[r][c] = 128'(m[r*3+c]);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                  - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
    det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
    if (det == 0) begin
      for (int k = 0; k < 9; k++) res.e[k] = m[k];
      res.singular = 1'b1;
      return res;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        // numerator stays below 2^97, well inside 128 bits
        num = cof[c][r] <<< (2*FRAC);
        quo = num / det;  // signed division truncates toward zero
        if (quo > 128'sd2147483647) begin
          res.e[r*3+c] = 32'sh7FFFFFFF;
          res.saturated = 1'b1;
        end else if (quo < -128'sd2147483648) begin
          res.e[r*3+c] = 32'sh80000000;
          res.saturated = 1'b1;
        end else begin
          res.e[r*3+c] = quo[31:0];
        end
      end
    return res;
  endfunction

  // Scoreboard: in-order queue of predicted inverses.
  class inverse_board;
    inverse_t pending [$];
    int errors;
    int results;
    int singular_seen;
    int saturated_seen;

    function void note_matrix(input mat_t m);
      pending.push_back(compute_inverse(m));
    endfunction

    function void check_inverse(input inverse_t got);
      inverse_t want;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, nothing pending", $time);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.singular) singular_seen++;
      if (want.saturated) saturated_seen++;
      for (int k = 0; k < 9; k++)
        if (got.e[k] !== want.e[k]) begin
          $display("%0t: element r%0dc%0d expected %h actual %h",
                   $time, k / 3, k % 3, want.e[k], got.e[k]);
          errors++;
        end
      if (got.singular !== want.singular) begin
        $display("%0t: singular expected %b actual %b", $time, want.singular, got.singular);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b",
                 $time, want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] in_elem [9];
  logic [31:0] out_elem [9];
  logic singular_o, saturated_o;

  inverse_board board;
  int cycle_count = 0;
  bit any_failure = 1'b0;

  always #5 clk_i = ~clk_i;

  initial for (int k = 0; k < 9; k++) in_elem[k] = '0;

  matrix3x3_inverse #(.FRAC_BITS(FRAC)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_r0c0_i(in_elem[0]), .in_r0c1_i(in_elem[1]), .in_r0c2_i(in_elem[2]),
    .in_r1c0_i(in_elem[3]), .in_r1c1_i(in_elem[4]), .in_r1c2_i(in_elem[5]),
    .in_r2c0_i(in_elem[6]), .in_r2c1_i(in_elem[7]), .in_r2c2_i(in_elem[8]),
    .out_valid_o, .out_stall_i,
    .out_r0c0_o(out_elem[0]), .out_r0c1_o(out_elem[1]), .out_r0c2_o(out_elem[2]),
    .out_r1c0_o(out_elem[3]), .out_r1c1_o(out_elem[4]), .out_r1c2_o(out_elem[5]),
    .out_r2c0_o(out_elem[6]), .out_r2c1_o(out_elem[7]), .out_r2c2_o(out_elem[8]),
    .singular_o, .saturated_o
  );

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: random stall pattern, sampled at the edge where the transaction happens.
  // Stretches of no stalling come from the stall_free phases.
  int stall_left = 0;
  bit stall_free = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      inverse_t got;
      for (int k = 0; k < 9; k++) got.e[k] = out_elem[k];
      got.singular = singular_o;
      got.saturated = saturated_o;
      board.check_inverse(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!stall_free && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Present one matrix and hold it until the block takes it.
  // Valid stays high across back-to-back transactions; it drops only for a gap.
  task automatic send_matrix(input mat_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int k = 0; k < 9; k++) in_elem[k] <= m[k];
    do @(posedge clk_i); while (in_stall_o);
    board.note_matrix(m);
  endtask

  function automatic elem_t rand_elem(input int style);
    case (style)
      0: return $urandom();                                   // full 32-bit range
      1: return $signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC); // about -4..4
      2: return $signed($urandom_range(0, 1 << 12)) - (1 << 11);     // tiny values
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 0;
          3: return 32'sh00010000;
          default: return 32'shFFFF0000;
        endcase
      end
      default: return $signed($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t m;
    int kind, style;
    kind = $urandom_range(0, 9);
    style = $urandom_range(0, 4);
    for (int k = 0; k < 9; k++)
      m[k] = ($urandom_range(0, 3) == 0) ? rand_elem($urandom_range(0, 4)) : rand_elem(style);
    // force singular: copy or negate a row, or zero a column
    if (kind == 0) begin
      for (int c = 0; c < 3; c++) m[6+c] = m[c];
    end else if (kind == 1) begin
      for (int c = 0; c < 3; c++) m[3+c] = -m[c];
    end else if (kind == 2) begin
      for (int r = 0; r < 3; r++) m[r*3+1] = 0;
    end
    return m;
  endfunction

  task automatic run_directed();
    mat_t m;
    // identity, signed diagonal, max/min diagonals, zero matrix
    m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_matrix(m);
    m = '{32'sh20000, 0, 0, 0, 32'shFFFE0000, 0, 0, 0, 32'sh8000};
    send_matrix(m);
    m = '{32'sh7FFFFFFF, 0, 0, 0, 32'sh7FFFFFFF, 0, 0, 0, 32'sh7FFFFFFF};
    send_matrix(m);
    m = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
    send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    // all ones and all minimums: singular, passed through
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_matrix(m);
    m = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    send_matrix(m);
    // smallest nonzero determinant: inverse saturates high and low
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    // permutation with signs, general well-conditioned
    m = '{0, 32'sh10000, 0, 0, 0, 32'shFFFF0000, 32'sh10000, 0, 0};
    send_matrix(m);
    m = '{32'sh20000, 32'sh10000, 0, 32'sh10000, 32'sh30000, 32'sh10000,
          0, 32'sh10000, 32'sh40000};
    send_matrix(m);
    // negative quotient of -2^24 without clipping
    m = '{32'sh100, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'shFFFFFF00};
    send_matrix(m);
    // mixed extreme elements, non-singular
    m = '{32'sh7FFFFFFF, 32'sh80000000, 1, -1, 32'sh7FFFFFFF, 0, 0, 1, 32'sh80000000};
    send_matrix(m);
    m = '{32'sh55555555, 32'shAAAAAAAA, 32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F,
          32'hF0F0F0F0, 32'h00FF00FF, 32'hFF00FF00, 32'h7F7F7F7F};
    send_matrix(m);
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int i = 0; i < N_RANDOM; i++) send_matrix(rand_matrix());
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("checked %0d inverses (%0d singular, %0d saturated) in %0d cycles",
             board.results, board.singular_seen, board.saturated_seen, cycle_count);
    any_failure = (board.errors != 0) || (board.pending.size() != 0);
    if (!any_failure) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
src/m3i_pkg.sv
src/m3i_div_stage.sv
src/matrix3x3_inverse.sv
tb/matrix3x3_inverse_test.sv
